@@ rtl/ordered_key_value_map_assert.svh @@
// Assertion macros used by the checker module.
`ifndef ORDERED_KEY_VALUE_MAP_ASSERT_SVH
`define ORDERED_KEY_VALUE_MAP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OKVM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define OKVM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/okvm_pkg.sv @@
package okvm_pkg;

    // Default sizes of the table.
    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 32;

    // Fixed field widths of the request and response channels.
    localparam int VALUE_BITS = 32;
    localparam int OUT_KEY_BITS = 32;
    localparam int COUNT_BITS = 9;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_LOWER  = 2'd2
    } okvm_req_t;

    // Response status codes.
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } okvm_status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } okvm_state_t;

    // Commands broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic upd_en;
    } okvm_ctrl_t;

endpackage

@@ rtl/okvm_if.sv @@
// Request channel: kind, key and value of one request.
interface okvm_req_if
    import okvm_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic signed [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

// Response channel: one result for each request.
interface okvm_rsp_if
    import okvm_pkg::*;
;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic signed [OUT_KEY_BITS-1:0] out_key;
    logic signed [VALUE_BITS-1:0]   out_value;
    logic [COUNT_BITS-1:0]          entry_count;
    logic                           is_empty;

    modport source (output valid, output status, output out_key, output out_value,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input status, input out_key, input out_value,
                    input entry_count, input is_empty, output ready);
endinterface

@@ rtl/okvm_cell.sv @@
module okvm_cell
    import okvm_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  okvm_ctrl_t                   ctrl,
    input  logic signed [KEY_BITS-1:0]   query_key,
    input  logic [VALUE_BITS-1:0]        query_value,
    input  logic                         cell_valid,
    input  logic                         prev_gep,
    input  logic signed [KEY_BITS-1:0]   prev_key,
    input  logic [VALUE_BITS-1:0]        prev_value,
    output logic                         gep,
    output logic signed [KEY_BITS-1:0]   key_q,
    output logic [VALUE_BITS-1:0]        value_q,
    output logic [KEY_BITS-1:0]          sel_key,
    output logic [VALUE_BITS-1:0]        sel_value,
    output logic                         sel_exact,
    output logic                         sel_found
);

    logic                       gep_reg;
    logic                       eq_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic [VALUE_BITS-1:0]      value_reg;
    logic                       hit;

    // Compare the stored key against the query. An empty cell counts as
    // not below the query, so the flags along the row form one step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gep_reg <= 1'b0;
            eq_reg  <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            gep_reg <= !cell_valid || (key_reg >= query_key);
            eq_reg  <= cell_valid && (key_reg == query_key);
        end
    end

    // The first cell not below the query is the one where the step rises.
    assign hit       = gep_reg && !prev_gep;
    assign sel_found = hit && cell_valid;
    assign sel_exact = sel_found && eq_reg;
    assign sel_key   = sel_found ? key_reg : '0;
    assign sel_value = sel_found ? value_reg : '0;

    // Shift right behind the insert point, take the new pair at it,
    // or overwrite the value of an exact match.
    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en)
        begin
            if (prev_gep)
            begin
                key_reg   <= prev_key;
                value_reg <= prev_value;
            end
            else if (gep_reg)
            begin
                key_reg   <= query_key;
                value_reg <= query_value;
            end
        end
        else if (ctrl.upd_en && sel_exact)
        begin
            value_reg <= query_value;
        end
    end

    assign gep     = gep_reg;
    assign key_q   = key_reg;
    assign value_q = value_reg;

endmodule

@@ rtl/ordered_key_value_map.sv @@
// Channel  Dir  Payload                                          Accepted when
// req      in   req_type, key, value                             req.valid && req.ready
// rsp      out  status, out_key, out_value, entry_count, is_empty rsp.valid && rsp.ready
//
// A request is compared in ST_CMP, where every cell of the row checks the key;
// then ST_APPLY picks the matching cell and shifts the row on an insert.
// A new request is taken in the cycle its predecessor's result is registered.
// The result waits in an output register; while it is not taken, the next
// request is compared but not applied.
// Reset (rst_n, asynchronous) empties the table; stored keys need no clearing.
module ordered_key_value_map
    import okvm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    okvm_req_if.sink   req,
    okvm_rsp_if.source rsp
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    okvm_state_t                state_reg, state_next;
    okvm_ctrl_t                 ctrl;
    logic                       advance;
    logic                       req_ready;

    logic [1:0]                 type_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic [VALUE_BITS-1:0]      value_reg;
    logic [CNT_BITS-1:0]        count_reg, count_next;

    logic [CAPACITY-1:0]        cell_valid;
    logic [CAPACITY-1:0]        cell_gep;
    logic [CAPACITY-1:0]        cell_exact;
    logic [CAPACITY-1:0]        cell_found;
    logic signed [KEY_BITS-1:0] cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0]      cell_value [CAPACITY];
    logic [KEY_BITS-1:0]        cell_skey  [CAPACITY];
    logic [VALUE_BITS-1:0]      cell_sval  [CAPACITY];

    logic [KEY_BITS-1:0]        match_key;
    logic [VALUE_BITS-1:0]      match_value;
    logic                       exact;
    logic                       found;
    logic                       full;
    logic                       is_insert;

    logic                       out_valid_reg;
    logic [1:0]                 status_reg, status_next;
    logic [OUT_KEY_BITS-1:0]    okey_reg, okey_next;
    logic [VALUE_BITS-1:0]      oval_reg, oval_next;
    logic [COUNT_BITS-1:0]      ocount_reg;
    logic                       oempty_reg;

    logic [KEY_BITS+OUT_KEY_BITS-1:0] key_ext;
    logic [CNT_BITS+COUNT_BITS-1:0]   count_ext;

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (advance)
                begin
                    state_next = req.valid ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        advance     = (state_reg == ST_APPLY) && (!out_valid_reg || rsp.ready);
        req_ready   = (state_reg == ST_IDLE) || advance;
        ctrl.cmp_en = (state_reg == ST_CMP);
        ctrl.upd_en = advance && is_insert && exact;
        ctrl.ins_en = advance && is_insert && !exact && !full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req.ready = req_ready;

    // Hold the request while it is worked on.
    always_ff @(posedge clk)
    begin
        if (req.valid && req_ready)
        begin
            type_reg  <= req.req_type;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
    end

    // Occupied cells form a prefix of the row.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_valid[i] = CNT_BITS'(i) < count_reg;
        end
    end

    // The row of cells, each linked to its left neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                       left_gep;
        logic signed [KEY_BITS-1:0] left_key;
        logic [VALUE_BITS-1:0]      left_value;

        if (i == 0)
        begin : g_head
            assign left_gep   = 1'b0;
            assign left_key   = '0;
            assign left_value = '0;
        end
        else
        begin : g_link
            assign left_gep   = cell_gep[i-1];
            assign left_key   = cell_key[i-1];
            assign left_value = cell_value[i-1];
        end

        okvm_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .query_key   (key_reg),
            .query_value (value_reg),
            .cell_valid  (cell_valid[i]),
            .prev_gep    (left_gep),
            .prev_key    (left_key),
            .prev_value  (left_value),
            .gep         (cell_gep[i]),
            .key_q       (cell_key[i]),
            .value_q     (cell_value[i]),
            .sel_key     (cell_skey[i]),
            .sel_value   (cell_sval[i]),
            .sel_exact   (cell_exact[i]),
            .sel_found   (cell_found[i])
        );
    end

    // At most one cell drives a match, so the pairs are simply ORed together.
    always_comb
    begin
        match_key   = '0;
        match_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_key   = match_key | cell_skey[i];
            match_value = match_value | cell_sval[i];
        end
    end

    assign exact     = |cell_exact;
    assign found     = |cell_found;
    assign full      = (count_reg == CNT_BITS'(CAPACITY));
    assign is_insert = (type_reg == REQ_INSERT);

    // Result of the request.
    always_comb
    begin
        status_next = STAT_MISS;
        okey_next   = '0;
        oval_next   = '0;
        key_ext     = {{OUT_KEY_BITS{match_key[KEY_BITS-1]}}, match_key};
        case (type_reg)
            REQ_INSERT:
            begin
                if (exact || !full)
                begin
                    status_next = STAT_OK;
                    key_ext     = {{OUT_KEY_BITS{key_reg[KEY_BITS-1]}}, key_reg};
                    okey_next   = key_ext[OUT_KEY_BITS-1:0];
                    oval_next   = value_reg;
                end
                else
                begin
                    status_next = STAT_FULL;
                end
            end
            REQ_FIND:
            begin
                if (exact)
                begin
                    status_next = STAT_OK;
                    okey_next   = key_ext[OUT_KEY_BITS-1:0];
                    oval_next   = match_value;
                end
            end
            REQ_LOWER:
            begin
                if (found)
                begin
                    status_next = STAT_OK;
                    okey_next   = key_ext[OUT_KEY_BITS-1:0];
                    oval_next   = match_value;
                end
            end
            default:
            begin
                status_next = STAT_MISS;
            end
        endcase
    end

    // Entry count after the request.
    assign count_next = ctrl.ins_en ? count_reg + CNT_BITS'(1) : count_reg;
    assign count_ext  = {{COUNT_BITS{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            okey_reg   <= okey_next;
            oval_reg   <= oval_next;
            ocount_reg <= count_ext[COUNT_BITS-1:0];
            oempty_reg <= (count_next == '0);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_key     = okey_reg;
    assign rsp.out_value   = oval_reg;
    assign rsp.entry_count = ocount_reg;
    assign rsp.is_empty    = oempty_reg;

endmodule

@@ rtl/okvm_checker.sv @@
`include "ordered_key_value_map_assert.svh"

module okvm_checker
    import okvm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic [1:0]              rsp_status,
    input logic [OUT_KEY_BITS-1:0] rsp_out_key,
    input logic [VALUE_BITS-1:0]   rsp_out_value,
    input logic [COUNT_BITS-1:0]   rsp_entry_count,
    input logic                    rsp_is_empty
);

    logic                                         req_take;
    logic                                         rsp_wait;
    logic [OUT_KEY_BITS+VALUE_BITS+COUNT_BITS+1:0] rsp_payload;
    logic                                         rsp_empty;
    logic                                         rsp_miss;
    logic                                         miss_clean;

    // Handshake and payload terms used by the checks below.
    assign req_take    = req_valid && req_ready;
    assign rsp_wait    = rsp_valid && !rsp_ready;
    assign rsp_payload = {rsp_status, rsp_out_key, rsp_out_value, rsp_entry_count};
    assign rsp_empty   = rsp_valid && rsp_is_empty;
    assign rsp_miss    = rsp_valid && (rsp_status == STAT_MISS || rsp_status == STAT_FULL);
    assign miss_clean  = (rsp_out_key == '0) && (rsp_out_value == '0)
                         && !(rsp_status == STAT_FULL && rsp_is_empty);

    // A request keeps the map busy, so none is taken in the following cycle.
    `OKVM_ASSERT_NEXT(a_busy_after_request, req_take, !req_ready, "request taken back to back")

    // A result that is not taken stays put.
    `OKVM_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_payload), "result moved")

    // The empty flag is only shown with a zero entry count.
    `OKVM_ASSERT_NOW(a_empty_flag, rsp_empty, rsp_entry_count == '0, "empty flag with entries")

    // A miss or refused insert carries no pair, and a refused insert means a nonempty table.
    `OKVM_ASSERT_NOW(a_no_pair, rsp_miss, miss_clean, "miss or refusal carries data")

endmodule

bind ordered_key_value_map okvm_checker u_okvm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_out_key     (rsp.out_key),
    .rsp_out_value   (rsp.out_value),
    .rsp_entry_count (rsp.entry_count),
    .rsp_is_empty    (rsp.is_empty)
);
